[rtl/tpc_pkg.sv]
// shared types, constants and register codes for the timed position controller
package tpc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_GAIN    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_POSITION = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RUN_TIME_US     = 3'd4;

  // saturation limits, Q16.16
  localparam logic signed [15:0] INTEG_LIMIT  = 16'sd6554;
  localparam logic signed [59:0] TORQUE_LIMIT = 60'sd39322;

  // error/500: x/4 then /125 by reciprocal, large magnitudes clamp
  localparam logic [33:0] DIV500_SAT  = 34'd6554500;
  localparam logic [13:0] DIV500_CLMP = 14'd13109;
  localparam logic [21:0] RECIP125    = 22'd2147484;   // ceil(2^28/125)

  // q/5 split as qh*(2^28-1)/5 + (qh+ql)/5, offset keeps the low part positive
  localparam logic signed [26:0] DIV5_HI  = 27'sd53687091;
  localparam logic [29:0]        DIV5_OFS = 30'd83886080; // 5*2^24
  localparam logic [29:0]        RECIP5   = 30'd858993460; // ceil(2^32/5)

  typedef struct packed {
    logic               feedback_fresh;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [31:0]        time_us;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] drive_torque;
    logic               run_done;
    logic [31:0]        elapsed_us;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_INT,
    ST_ICALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_err;
    logic calc_mul;
    logic calc_int;
    logic calc_icalc;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic result_held;
  } status_t;

endpackage

[rtl/tpc_ctrl.sv]
// sequencer for the position controller datapath
module tpc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             feedback_fresh,
  input  tpc_pkg::status_t status,
  output logic             sample_stall,
  output tpc_pkg::cmd_t    cmd
);
  import tpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_valid && feedback_fresh) state_next = ST_ERR;
      end
      ST_ERR:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_INT;
      ST_INT:   state_next = ST_ICALC;
      ST_ICALC: state_next = ST_OUT;
      ST_OUT: begin
        if (!status.result_held) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid && feedback_fresh;
      end
      ST_ERR:   cmd.calc_err   = 1'b1;
      ST_MUL:   cmd.calc_mul   = 1'b1;
      ST_INT:   cmd.calc_int   = 1'b1;
      ST_ICALC: cmd.calc_icalc = 1'b1;
      ST_OUT:   cmd.write      = !status.result_held;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/tpc_datapath.sv]
// config registers, controller arithmetic, run timing and result register
module tpc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  input  tpc_pkg::sample_t                    sample,
  input  tpc_pkg::cmd_t                       cmd,
  output tpc_pkg::status_t                    status,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tpc_pkg::result_t                    result
);
  import tpc_pkg::*;

  // configuration
  logic signed [31:0] position_gain;
  logic signed [31:0] damping_gain;
  logic signed [31:0] integral_gain;
  logic signed [31:0] target_position;
  logic [31:0]        run_time_us;

  // controller state
  logic               first_sample;
  logic [31:0]        start_stamp;
  logic signed [13:0] error_integral;

  // working registers
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;
  logic [31:0]        time_r;
  logic signed [32:0] err_r;
  logic [31:0]        elapsed_r;
  logic signed [63:0] prod_d;
  logic signed [64:0] prod_p;
  logic signed [45:0] prod_i;
  logic signed [14:0] inc_r;
  logic               done_r;
  logic signed [52:0] hi_r;
  logic [26:0]        q5_r;
  logic signed [57:0] acc_r;

  // combinational
  logic [31:0]        start_eff;
  logic [32:0]        err_mag;
  logic [33:0]        div_x;
  logic [42:0]        div_prod;
  logic [13:0]        inc_mag;
  logic signed [14:0] inc_next;
  logic signed [26:0] qh;
  logic [27:0]        ql;
  logic signed [29:0] s_ofs;
  logic [58:0]        q5_prod;
  logic signed [15:0] integ_sum;
  logic signed [13:0] integ_next;
  logic signed [57:0] acc_next;
  logic signed [58:0] sum;
  logic signed [59:0] rnd;
  logic signed [59:0] tq;
  logic signed [16:0] torque_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_gain   <= '0;
      damping_gain    <= '0;
      integral_gain   <= '0;
      target_position <= '0;
      run_time_us     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POSITION_GAIN:   position_gain   <= cfg_data;
        REG_DAMPING_GAIN:    damping_gain    <= cfg_data;
        REG_INTEGRAL_GAIN:   integral_gain   <= cfg_data;
        REG_TARGET_POSITION: target_position <= cfg_data;
        REG_RUN_TIME_US:     run_time_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign start_eff = first_sample ? time_r : start_stamp;

  // rounded error/500 with ties away from zero, clamped for large magnitudes
  always_comb begin
    err_mag  = err_r[32] ? 33'(-err_r) : 33'(err_r);
    div_x    = 34'(err_mag) + 34'd250;
    div_prod = 43'(div_x[22:2]) * 43'(RECIP125);
    if (div_x >= DIV500_SAT) begin
      inc_mag = DIV500_CLMP;
    end else begin
      inc_mag = div_prod[41:28];
    end
    inc_next = err_r[32] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
  end

  // floor(prod_d / 2560) pieces: q = prod_d >>> 9 split at bit 28
  always_comb begin
    qh      = prod_d[63:37];
    ql      = prod_d[36:9];
    s_ofs   = 30'(qh) + $signed({2'b00, ql}) + $signed(DIV5_OFS);
    q5_prod = 59'(s_ofs[28:0]) * 59'(RECIP5);
  end

  always_comb begin
    integ_sum = 16'(error_integral) + 16'(inc_r);
    if (integ_sum > INTEG_LIMIT) begin
      integ_next = 14'(INTEG_LIMIT);
    end else if (integ_sum < -INTEG_LIMIT) begin
      integ_next = 14'(-INTEG_LIMIT);
    end else begin
      integ_next = 14'(integ_sum);
    end
  end

  assign acc_next = 58'(prod_p >>> 8)
                  - (58'(hi_r) + $signed({31'd0, q5_r}) - 58'sd16777216);

  always_comb begin
    sum = 59'(acc_r) + 59'(prod_i >>> 8);
    rnd = 60'(sum) + 60'sd32768;
    tq  = rnd >>> 16;
    if (done_r) begin
      torque_next = '0;
    end else if (tq > TORQUE_LIMIT) begin
      torque_next = 17'(TORQUE_LIMIT);
    end else if (tq < -TORQUE_LIMIT) begin
      torque_next = 17'(-TORQUE_LIMIT);
    end else begin
      torque_next = tq[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= sample.position;
      vel_r  <= sample.velocity;
      time_r <= sample.time_us;
    end
    if (cmd.calc_err) begin
      err_r     <= 33'(target_position) - 33'(pos_r);
      elapsed_r <= time_r - start_eff;
      prod_d    <= 64'(vel_r) * 64'(damping_gain);
    end
    if (cmd.calc_mul) begin
      prod_p <= 65'(err_r) * 65'(position_gain);
      inc_r  <= inc_next;
      done_r <= elapsed_r >= run_time_us;
      hi_r   <= 53'(qh) * 53'(DIV5_HI);
      q5_r   <= q5_prod[58:32];
    end
    if (cmd.calc_int) begin
      acc_r <= acc_next;
    end
    if (cmd.calc_icalc) begin
      prod_i <= 46'(error_integral) * 46'(integral_gain);
    end
    if (cmd.write) begin
      result.drive_torque <= torque_next;
      result.run_done     <= done_r;
      result.elapsed_us   <= elapsed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample   <= 1'b1;
      start_stamp    <= '0;
      error_integral <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.calc_err) begin
        start_stamp  <= start_eff;
        first_sample <= 1'b0;
      end
      if (cmd.calc_int) begin
        error_integral <= integ_next;
      end
      if (cmd.write && done_r) begin
        first_sample <= 1'b1;
      end
      if (cmd.write) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.result_held = result_valid && result_stall;

  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (error_integral <= 14'sd6554) && (error_integral >= -14'sd6554))
    else $error("integrator outside its saturation range");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.run_done |-> result.drive_torque == 17'sd0)
    else $error("run end beat carries nonzero torque");

  a_torque_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.drive_torque <= 17'sd39322)
                     && (result.drive_torque >= -17'sd39322))
    else $error("torque beyond saturation limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !(result_valid && result_stall))
    else $error("result register overwritten while held");

  a_run_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.write && done_r |=> first_sample)
    else $error("run end did not rearm start time capture");

endmodule

[rtl/timed_position_pi_controller_top.sv]
// top level of the timed pi position controller with velocity damping
//
// sample channel: one motor feedback beat (fresh flag, position, velocity,
//   microsecond timestamp) is taken when sample_valid is high and
//   sample_stall is low. a beat with feedback_fresh low is dropped with no
//   result and no state change.
// result channel: one beat (drive_torque, run_done, elapsed_us) per fresh
//   sample, taken when result_valid is high and result_stall is low.
// config channel: cfg_valid/cfg_ready write with cfg_index 0..4 (position,
//   damping and integral gain, target position, run time); other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
// timing: a fresh sample steps through error, multiply, integrator, integral
//   term and output, and no new sample is taken until its result is written;
//   stale samples are dropped while idle. these five steps hold the multiply
//   and divide-by-constant stages.
// stall: the result register holds its beat; a finished sample then waits
//   in the last step and no new sample is taken until the beat drains.
// reset (rst, synchronous): clears gains, target, run time, integrator and
//   start time, and arms the next fresh sample to start a run.
module timed_position_pi_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  tpc_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tpc_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import tpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // registers are plain flops, so a write is always taken
  assign cfg_ready = 1'b1;

  // sequencer: idle, error, multiplies, integrator, integral term, output
  tpc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .feedback_fresh (sample.feedback_fresh),
    .status         (status),
    .sample_stall   (sample_stall),
    .cmd            (cmd)
  );

  // arithmetic, run timing state and the result register
  tpc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
